FILE: hw/rtl/csp_pkg.sv
package csp_pkg;

    localparam int unsigned SYM_W      = 6;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 11;
    localparam int unsigned POS_W      = 10;
    localparam int unsigned PAIR_CNT_W = 2;
    localparam int unsigned PART_W     = 6;
    localparam int unsigned APB_DW     = 32;
    localparam int unsigned APB_AW     = 1;

    localparam logic [LEN_W-1:0] BLOCK_MAX       = LEN_W'(1024);
    localparam logic [LEN_W-1:0] BLOCK_LEN_RESET = LEN_W'(4);

    localparam logic [PAIR_CNT_W-1:0] LAST_PAIR = PAIR_CNT_W'(3);

    // register map, byte addresses
    localparam logic [APB_AW-1:0] ADDR_BLOCK_LENGTH = APB_AW'(0);

    typedef logic [SYM_W-1:0]  symbol_t;
    typedef logic [BYTE_W-1:0] byte_t;

endpackage

FILE: hw/rtl/csp_if.sv
interface csp_in_if;
    import csp_pkg::*;

    logic    valid;
    logic    ready;
    symbol_t symbol;
    logic    start_of_call;

    modport source (output valid, output symbol, output start_of_call, input ready);
    modport sink   (input valid, input symbol, input start_of_call, output ready);
endinterface

interface csp_out_if;
    import csp_pkg::*;

    logic  valid;
    logic  ready;
    byte_t packed_byte;

    modport source (output valid, output packed_byte, input ready);
    modport sink   (input valid, input packed_byte, output ready);
endinterface

FILE: hw/rtl/convolutional_syndrome_packer.sv
// channel  dir  handshake      payload
// in_ch    in   valid/ready    symbol[5:0], start_of_call
// out_ch   out  valid/ready    packed_byte[7:0]
// apb      in   psel/penable   paddr[0], pwdata[31:0] -> prdata[31:0]
//
// One word per cycle while in_ch.ready is high: the delay, position and packing
// state update in the accept cycle and a finished byte lands in the output register.
// in_ch.ready is high whenever the output register is empty or being drained.
// Reset clears all state but out_byte_reg; block_length returns to 4 and the first
// block of symbols after reset is dropped.
module convolutional_syndrome_packer
(
    input  logic                          clk,
    input  logic                          rst_n,
    csp_in_if.sink                        in_ch,
    csp_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [csp_pkg::APB_AW-1:0]    paddr,
    input  logic [csp_pkg::APB_DW-1:0]    pwdata,
    output logic [csp_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import csp_pkg::*;

    logic [LEN_W-1:0]      block_length_reg;
    logic                  delay_one_reg, delay_one_next;
    logic                  delay_two_reg, delay_two_next;
    logic [POS_W-1:0]      block_position_reg, block_position_next;
    logic [PAIR_CNT_W-1:0] bit_pair_count_reg, bit_pair_count_next;
    logic [PART_W-1:0]     partial_bits_reg, partial_bits_next;
    logic                  skip_done_reg, skip_done_next;
    logic [POS_W-1:0]      skip_count_reg, skip_count_next;
    logic                  out_valid_reg, out_valid_next;
    byte_t                 out_byte_reg, out_byte_next;

    logic                  accept;
    logic                  cfg_write;
    logic [LEN_W-1:0]      eff_len;
    logic [POS_W-1:0]      pos_now;
    logic [PAIR_CNT_W-1:0] cnt_now;
    logic [PART_W-1:0]     part_now;
    logic                  d1_now, d2_now;
    logic                  s1, s2, w;
    logic [LEN_W-1:0]      pos_inc, skip_inc;
    logic                  emit;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_BLOCK_LENGTH);
    assign prdata    = (paddr == ADDR_BLOCK_LENGTH) ? APB_DW'(block_length_reg) : '0;

    assign in_ch.ready        = !out_valid_reg || out_ch.ready;
    assign accept             = in_ch.valid && in_ch.ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.packed_byte = out_byte_reg;

    always_comb
    begin
        // zero acts as one, anything past 1024 saturates
        if (block_length_reg == '0)
            eff_len = LEN_W'(1);
        else if (block_length_reg > BLOCK_MAX)
            eff_len = BLOCK_MAX;
        else
            eff_len = block_length_reg;

        pos_now  = in_ch.start_of_call ? '0 : block_position_reg;
        cnt_now  = in_ch.start_of_call ? '0 : bit_pair_count_reg;
        part_now = in_ch.start_of_call ? '0 : partial_bits_reg;
        d1_now   = (pos_now == '0) ? 1'b0 : delay_one_reg;
        d2_now   = (pos_now == '0) ? 1'b0 : delay_two_reg;

        s1 = d1_now ^ in_ch.symbol[5] ^ in_ch.symbol[4] ^ in_ch.symbol[1];
        w  = d2_now ^ in_ch.symbol[5] ^ in_ch.symbol[4] ^ in_ch.symbol[3];
        s2 = w ^ in_ch.symbol[2] ^ in_ch.symbol[0];

        pos_inc  = LEN_W'(pos_now) + LEN_W'(1);
        skip_inc = LEN_W'(skip_count_reg) + LEN_W'(1);

        delay_one_next      = delay_one_reg;
        delay_two_next      = delay_two_reg;
        block_position_next = block_position_reg;
        bit_pair_count_next = bit_pair_count_reg;
        partial_bits_next   = partial_bits_reg;
        skip_done_next      = skip_done_reg;
        skip_count_next     = skip_count_reg;
        emit                = 1'b0;
        out_byte_next       = out_byte_reg;

        if (accept)
        begin
            block_position_next = pos_now;
            bit_pair_count_next = cnt_now;
            partial_bits_next   = part_now;
            if (!skip_done_reg)
            begin
                if (skip_inc >= eff_len)
                begin
                    skip_done_next  = 1'b1;
                    skip_count_next = '0;
                end
                else
                begin
                    skip_count_next = skip_inc[POS_W-1:0];
                end
            end
            else
            begin
                delay_one_next = d1_now ^ in_ch.symbol[5] ^ in_ch.symbol[3]
                                 ^ in_ch.symbol[2];
                delay_two_next = w;
                block_position_next = (pos_inc >= eff_len) ? '0 : pos_inc[POS_W-1:0];
                if (cnt_now == LAST_PAIR)
                begin
                    emit                = 1'b1;
                    out_byte_next       = {part_now, s1, s2};
                    partial_bits_next   = '0;
                    bit_pair_count_next = '0;
                end
                else
                begin
                    partial_bits_next   = {part_now[PART_W-3:0], s1, s2};
                    bit_pair_count_next = cnt_now + PAIR_CNT_W'(1);
                end
            end
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg   <= BLOCK_LEN_RESET;
            delay_one_reg      <= 1'b0;
            delay_two_reg      <= 1'b0;
            block_position_reg <= '0;
            bit_pair_count_reg <= '0;
            partial_bits_reg   <= '0;
            skip_done_reg      <= 1'b0;
            skip_count_reg     <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                block_length_reg <= pwdata[LEN_W-1:0];
            delay_one_reg      <= delay_one_next;
            delay_two_reg      <= delay_two_next;
            block_position_reg <= block_position_next;
            bit_pair_count_reg <= bit_pair_count_next;
            partial_bits_reg   <= partial_bits_next;
            skip_done_reg      <= skip_done_next;
            skip_count_reg     <= skip_count_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
    end

endmodule
